>>> design/i2cm_pkg.sv
// Package with types, command codes and step tables for the I2C master pin sequencer
`timescale 1ns / 1ps

package i2cm_pkg;

  // Command codes
  localparam logic [2:0] CMD_NONE     = 3'd0;
  localparam logic [2:0] CMD_START    = 3'd1;
  localparam logic [2:0] CMD_STOP     = 3'd2;
  localparam logic [2:0] CMD_WRITE    = 3'd3;
  localparam logic [2:0] CMD_READ     = 3'd4;
  localparam logic [2:0] CMD_SEND_ACK = 3'd5;
  localparam logic [2:0] CMD_RECV_ACK = 3'd6;

  localparam logic [7:0]  BIT_TOP          = 8'h80;
  localparam logic [15:0] STEP_CYCLES_RST  = 16'd100;

  // Input beat: one bus timer tick
  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] tx_byte;
    logic       ack_out;
    logic       sda_in;
  } in_beat_t;

  // Output beat: pin drive and status after the tick
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_received;
  } out_beat_t;

  // Context handed to the step decoder
  typedef struct packed {
    logic [2:0] cmd;
    logic [4:0] step;
    logic [1:0] phase;
    logic [2:0] bitn;
    logic [7:0] shreg;
    logic       scl;
    logic       sda;
    logic       last_ack;
    logic       ack_out;
    logic       sda_in;
  } step_ctx_t;

  // Pin and data state after a step action
  typedef struct packed {
    logic       scl;
    logic       sda;
    logic [7:0] shreg;
    logic       last_ack;
  } step_res_t;

  // Number of pin steps of each command; zero means not a command
  function automatic logic [4:0] steps_of(input logic [2:0] cmd);
    logic [4:0] n;
    case (cmd)
      CMD_START:    n = 5'd4;
      CMD_STOP:     n = 5'd3;
      CMD_WRITE:    n = 5'd24;
      CMD_READ:     n = 5'd25;
      CMD_SEND_ACK: n = 5'd3;
      CMD_RECV_ACK: n = 5'd4;
      default:      n = 5'd0;
    endcase
    return n;
  endfunction

endpackage

>>> design/i2cm_step_dec.sv
// Pin action of one step: decodes command, step and bit phase into new pin drive
`timescale 1ns / 1ps

module i2cm_step_dec (
  input  i2cm_pkg::step_ctx_t ctx,
  output i2cm_pkg::step_res_t res
);
  import i2cm_pkg::*;

  logic [7:0] mask;

  assign mask = BIT_TOP >> ctx.bitn;

  always_comb begin
    res.scl      = ctx.scl;
    res.sda      = ctx.sda;
    res.shreg    = ctx.shreg;
    res.last_ack = ctx.last_ack;
    case (ctx.cmd)
      CMD_START: begin
        case (ctx.step[1:0])
          2'd0:    res.sda = 1'b1;
          2'd1:    res.scl = 1'b1;
          2'd2:    res.sda = 1'b0;
          default: res.scl = 1'b0;
        endcase
      end
      CMD_STOP: begin
        case (ctx.step[1:0])
          2'd0:    res.sda = 1'b0;
          2'd1:    res.scl = 1'b1;
          default: res.sda = 1'b1;
        endcase
      end
      CMD_WRITE: begin
        // data bit, clock high, clock low
        case (ctx.phase)
          2'd0:    res.sda = |(ctx.shreg & mask);
          2'd1:    res.scl = 1'b1;
          default: res.scl = 1'b0;
        endcase
      end
      CMD_READ: begin
        // release SDA first, then clock high, sample, clock low per bit
        if (ctx.step == 5'd0) begin
          res.sda = 1'b1;
        end else begin
          case (ctx.phase)
            2'd0:    res.scl = 1'b1;
            2'd1:    res.shreg = ctx.sda_in ? (ctx.shreg | mask) : ctx.shreg;
            default: res.scl = 1'b0;
          endcase
        end
      end
      CMD_SEND_ACK: begin
        case (ctx.step[1:0])
          2'd0:    res.sda = ctx.ack_out;
          2'd1:    res.scl = 1'b1;
          default: res.scl = 1'b0;
        endcase
      end
      CMD_RECV_ACK: begin
        case (ctx.step[1:0])
          2'd0:    res.sda = 1'b1;
          2'd1:    res.scl = 1'b1;
          2'd2:    res.last_ack = ctx.sda_in;
          default: res.scl = 1'b0;
        endcase
      end
      default: ;
    endcase
  end

endmodule

>>> design/i2c_master_bit_sequencer.sv
// Top level of the I2C master pin sequencer
`timescale 1ns / 1ps

// Every input beat is one tick of the bus timer and yields exactly one output beat in the next
// cycle, from a single output register; one beat is taken per cycle whenever that register is
// empty or being drained in the same cycle. A command (start, stop, write byte, read byte, send
// ack, receive ack) is taken only when the sequencer is idle and is played as a list of pin steps,
// each lasting step_cycles ticks (zero counts as one); the pin action lands on the first tick of
// a step and the accepting tick is the first tick of step zero. done_res is high on the last
// tick of the last step, busy_res already low on that tick. SDA and SCL levels of 1 mean the line
// is released. step_cycles resets to 100; user writes it over cfg channel while idle (unchecked).
module i2c_master_bit_sequencer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  i2cm_pkg::in_beat_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output i2cm_pkg::out_beat_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [15:0]          cfg_data
);
  import i2cm_pkg::*;

  // Sequencer state
  logic [15:0] step_cycles_r;
  logic [2:0]  cmd_r,   cmd_nxt;
  logic [4:0]  step_r,  step_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [2:0]  bitn_r,  bitn_nxt;
  logic [15:0] tick_r,  tick_nxt;
  logic [7:0]  shreg_r, shreg_nxt;
  logic        scl_r,   sda_r;
  logic [7:0]  rx_r,    rx_nxt;
  logic        ack_r;
  logic        out_valid_r;
  out_beat_t   out_r,   out_nxt;

  logic        in_fire;
  logic        launch;
  logic [2:0]  cmd_cur;
  logic [4:0]  step_cur;
  logic [1:0]  phase_cur;
  logic [2:0]  bitn_cur;
  logic [15:0] tick_cur;
  logic [7:0]  shreg_cur;
  logic [15:0] limit;
  logic        step_end;
  logic        cmd_end;
  logic        done;
  step_ctx_t   ctx;
  step_res_t   act;
  step_res_t   res;

  assign in_fire   = in_valid && in_ready;
  assign in_ready  = !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Load a new command only from idle
  assign launch    = (cmd_r == CMD_NONE) && (steps_of(in_data.cmd) != 5'd0);
  assign cmd_cur   = launch ? in_data.cmd : cmd_r;
  assign step_cur  = launch ? 5'd0 : step_r;
  assign phase_cur = launch ? 2'd0 : phase_r;
  assign bitn_cur  = launch ? 3'd0 : bitn_r;
  assign tick_cur  = launch ? 16'd0 : tick_r;
  assign shreg_cur = launch ? ((in_data.cmd == CMD_WRITE) ? in_data.tx_byte : 8'd0) : shreg_r;

  assign ctx = '{cmd: cmd_cur, step: step_cur, phase: phase_cur, bitn: bitn_cur,
                 shreg: shreg_cur, scl: scl_r, sda: sda_r, last_ack: ack_r,
                 ack_out: in_data.ack_out, sda_in: in_data.sda_in};

  i2cm_step_dec u_dec (
    .ctx (ctx),
    .res (act)
  );

  // Pin action only on the first tick of a step
  assign res = (cmd_cur != CMD_NONE && tick_cur == 16'd0)
             ? act
             : step_res_t'{scl: scl_r, sda: sda_r, shreg: shreg_cur, last_ack: ack_r};

  // Step timing
  assign limit    = (step_cycles_r == 16'd0) ? 16'd1 : step_cycles_r;
  assign step_end = ({1'b0, tick_cur} + 17'd1) >= {1'b0, limit};
  assign cmd_end  = ({1'b0, step_cur} + 6'd1) >= {1'b0, steps_of(cmd_cur)};
  assign done     = (cmd_cur != CMD_NONE) && step_end && cmd_end;

  // Next state of the sequencer
  always_comb begin
    cmd_nxt   = cmd_cur;
    step_nxt  = step_cur;
    phase_nxt = phase_cur;
    bitn_nxt  = bitn_cur;
    tick_nxt  = tick_cur;
    shreg_nxt = res.shreg;
    rx_nxt    = rx_r;
    if (cmd_cur != CMD_NONE) begin
      if (step_end) begin
        tick_nxt = 16'd0;
        if (cmd_end) begin
          if (cmd_cur == CMD_READ) begin
            rx_nxt = res.shreg;
          end
          cmd_nxt  = CMD_NONE;
          step_nxt = 5'd0;
        end else begin
          step_nxt = step_cur + 5'd1;
          // the release step of a read does not advance the bit phase
          if (!(cmd_cur == CMD_READ && step_cur == 5'd0)) begin
            if (phase_cur == 2'd2) begin
              phase_nxt = 2'd0;
              bitn_nxt  = bitn_cur + 3'd1;
            end else begin
              phase_nxt = phase_cur + 2'd1;
            end
          end
        end
      end else begin
        tick_nxt = tick_cur + 16'd1;
      end
    end
  end

  assign out_nxt = '{scl_level: res.scl, sda_level: res.sda, busy_res: cmd_nxt != CMD_NONE,
                     done_res: done, rx_byte: rx_nxt, ack_received: res.last_ack};

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_cycles_r <= STEP_CYCLES_RST;
    end else if (cfg_valid && cfg_ready) begin
      step_cycles_r <= cfg_data;
    end
  end

  // Sequencer registers, advanced once per input beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r   <= CMD_NONE;
      step_r  <= 5'd0;
      phase_r <= 2'd0;
      bitn_r  <= 3'd0;
      tick_r  <= 16'd0;
      shreg_r <= 8'd0;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
      rx_r    <= 8'd0;
      ack_r   <= 1'b1;
    end else if (in_fire) begin
      cmd_r   <= cmd_nxt;
      step_r  <= step_nxt;
      phase_r <= phase_nxt;
      bitn_r  <= bitn_nxt;
      tick_r  <= tick_nxt;
      shreg_r <= shreg_nxt;
      scl_r   <= res.scl;
      sda_r   <= res.sda;
      rx_r    <= rx_nxt;
      ack_r   <= res.last_ack;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_r <= out_nxt;
    end
  end

endmodule

>>> design/i2cm_checker.sv
// Port level checks for the I2C master pin sequencer, bound to the top level
`timescale 1ns / 1ps

module i2cm_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input i2cm_pkg::out_beat_t out_data,
  input logic                out_valid,
  input logic                out_ready
);
  import i2cm_pkg::*;

  // a held result beat does not change
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // every accepted tick produces a result beat next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted beat produced no result");

  // an empty output register never stalls the input
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  // a finishing command is no longer busy
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.done_res && out_data.busy_res))
    else $error("done and busy together");

endmodule

bind i2c_master_bit_sequencer i2cm_checker u_i2cm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_data  (out_data),
  .out_valid (out_valid),
  .out_ready (out_ready)
);

>>> test/i2c_master_bit_sequencer_tb.sv
// Self-checking testbench for the I2C master pin sequencer: tick predictor, random beats, stalls
`timescale 1ns / 1ps

module i2c_master_bit_sequencer_tb;
  import i2cm_pkg::*;

  localparam int STALL_LIMIT = 2000;   // cycles with no beat on any channel
  localparam int IDLE_PCT    = 26;     // chance per cycle that a side idles
  localparam int NOISE_PCT   = 15;     // chance of a stray command on a busy tick
  localparam int REPORT_MAX  = 200;    // cap on printed mismatch lines
  localparam int SDA_LOW     = 0;
  localparam int SDA_HIGH    = 1;
  localparam int SDA_RANDOM  = 2;
  // start, address, ack, three data bytes with acks, stop
  localparam int unsigned TXN_STEPS_MAX = 119;
  localparam logic [2:0] CMD_UNUSED = 3'd7;   // code that starts nothing

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_beat_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_beat_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  // Tick beats waiting to be driven and pin states waiting to be seen
  in_beat_t    pending_ticks[$];
  out_beat_t   expected_pins[$];
  int unsigned ticks_queued  = 0;
  int unsigned ticks_checked = 0;
  int unsigned mismatches    = 0;
  int unsigned stall_cycles  = 0;
  logic        calm          = 1'b0;   // no idling on either side while set

  // Predicted sequencer state
  logic [15:0] step_cycles_cfg = STEP_CYCLES_RST;
  logic [2:0]  seq_cmd   = CMD_NONE;
  logic [4:0]  seq_step  = 5'd0;
  logic [15:0] seq_ticks = 16'd0;
  logic [7:0]  seq_shift = 8'h00;
  logic        seq_scl   = 1'b1;
  logic        seq_sda   = 1'b1;
  logic [7:0]  seq_rx    = 8'h00;
  logic        seq_ack   = 1'b1;

  i2c_master_bit_sequencer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // Pin steps per command, zero for codes that start nothing
  function automatic logic [4:0] step_total(logic [2:0] c);
    case (c)
      CMD_START, CMD_RECV_ACK: return 5'd4;
      CMD_STOP, CMD_SEND_ACK:  return 5'd3;
      CMD_WRITE:               return 5'd24;
      CMD_READ:                return 5'd25;
      default:                 return 5'd0;
    endcase
  endfunction

  // Pin action on the first tick of the current step
  function automatic void pin_action(logic ack_lvl, logic sda_smp);
    int unsigned pos;
    int unsigned bitn;
    int unsigned phase;
    case (seq_cmd)
      CMD_START: begin
        case (seq_step)
          5'd0:    seq_sda = 1'b1;
          5'd1:    seq_scl = 1'b1;
          5'd2:    seq_sda = 1'b0;
          default: seq_scl = 1'b0;
        endcase
      end
      CMD_STOP: begin
        case (seq_step)
          5'd0:    seq_sda = 1'b0;
          5'd1:    seq_scl = 1'b1;
          default: seq_sda = 1'b1;
        endcase
      end
      CMD_WRITE: begin
        bitn  = seq_step / 3;
        phase = seq_step % 3;
        if (phase == 0) seq_sda = seq_shift[7 - bitn];
        else if (phase == 1) seq_scl = 1'b1;
        else seq_scl = 1'b0;
      end
      CMD_READ: begin
        if (seq_step == 5'd0) begin
          seq_sda = 1'b1;
        end else begin
          pos   = seq_step - 1;
          bitn  = pos / 3;
          phase = pos % 3;
          if (phase == 0) seq_scl = 1'b1;
          else if (phase == 1) begin
            if (sda_smp) seq_shift[7 - bitn] = 1'b1;
          end else seq_scl = 1'b0;
        end
      end
      CMD_SEND_ACK: begin
        case (seq_step)
          5'd0:    seq_sda = ack_lvl;
          5'd1:    seq_scl = 1'b1;
          default: seq_scl = 1'b0;
        endcase
      end
      CMD_RECV_ACK: begin
        case (seq_step)
          5'd0:    seq_sda = 1'b1;
          5'd1:    seq_scl = 1'b1;
          5'd2:    seq_ack = sda_smp;
          default: seq_scl = 1'b0;
        endcase
      end
      default: ;
    endcase
  endfunction

  // Advance the predicted sequencer by one tick and return the pin state after it
  function automatic out_beat_t sequencer_tick(in_beat_t b);
    out_beat_t  r;
    logic [16:0] span;
    logic        done;
    span = (step_cycles_cfg == 16'd0) ? 17'd1 : {1'b0, step_cycles_cfg};
    done = 1'b0;
    if (seq_cmd == CMD_NONE && step_total(b.cmd) != 5'd0) begin
      seq_cmd   = b.cmd;
      seq_step  = 5'd0;
      seq_ticks = 16'd0;
      seq_shift = (b.cmd == CMD_WRITE) ? b.tx_byte : 8'h00;
    end
    if (seq_cmd != CMD_NONE) begin
      if (seq_ticks == 16'd0) pin_action(b.ack_out, b.sda_in);
      if ({1'b0, seq_ticks} + 17'd1 >= span) begin
        seq_ticks = 16'd0;
        if ({1'b0, seq_step} + 6'd1 >= {1'b0, step_total(seq_cmd)}) begin
          if (seq_cmd == CMD_READ) seq_rx = seq_shift;
          seq_cmd  = CMD_NONE;
          seq_step = 5'd0;
          done     = 1'b1;
        end else begin
          seq_step = seq_step + 5'd1;
        end
      end else begin
        seq_ticks = seq_ticks + 16'd1;
      end
    end
    r.scl_level    = seq_scl;
    r.sda_level    = seq_sda;
    r.busy_res     = (seq_cmd != CMD_NONE);
    r.done_res     = done;
    r.rx_byte      = seq_rx;
    r.ack_received = seq_ack;
    return r;
  endfunction

  // Input driver: presents queued ticks, idles at random
  always @(posedge clk) begin : tick_driver
    in_beat_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) expected_pins.push_back(sequencer_tick(in_data));
      if (!in_valid || in_ready) begin
        if (pending_ticks.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          nxt = pending_ticks.pop_front();
          in_data  <= nxt;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string fname, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("%0t: %s expected %0h actual %0h", $time, fname, want, got);
    end
  endtask

  // Result monitor: stalls at random, checks each beat against the oldest prediction
  always @(posedge clk) begin : pin_monitor
    out_beat_t want;
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    if (rst_n && out_valid && out_ready) begin
      if (expected_pins.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: unexpected beat, expected none actual %h", $time, out_data);
      end else begin
        want = expected_pins.pop_front();
        ticks_checked++;
        check_field("scl_level", 8'(want.scl_level), 8'(out_data.scl_level));
        check_field("sda_level", 8'(want.sda_level), 8'(out_data.sda_level));
        check_field("busy_res", 8'(want.busy_res), 8'(out_data.busy_res));
        check_field("done_res", 8'(want.done_res), 8'(out_data.done_res));
        check_field("rx_byte", want.rx_byte, out_data.rx_byte);
        check_field("ack_received", 8'(want.ack_received), 8'(out_data.ack_received));
      end
    end
  end

  // Count cycles with no beat anywhere
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("i2c_master_bit_sequencer regression: fail");
    $finish;
  end

  function automatic logic pick_sda(int mode);
    if (mode == SDA_RANDOM) return 1'($urandom_range(0, 1));
    return mode[0];
  endfunction

  task automatic push_tick(in_beat_t t);
    pending_ticks.push_back(t);
    ticks_queued++;
  endtask

  task automatic push_idle_tick();
    in_beat_t t;
    t.cmd     = CMD_NONE;
    t.tx_byte = 8'($urandom_range(0, 255));
    t.ack_out = 1'($urandom_range(0, 1));
    t.sda_in  = 1'($urandom_range(0, 1));
    push_tick(t);
  endtask

  // One command beat, then enough ticks to play it out, then a short gap
  task automatic queue_command(logic [2:0] c, logic [7:0] tx, logic ack, int sda_mode,
                               int noise_pct);
    in_beat_t    t;
    int unsigned span;
    int unsigned ticks;
    int unsigned k;
    span  = (step_cycles_cfg == 16'd0) ? 1 : step_cycles_cfg;
    ticks = step_total(c) * span;
    t.cmd     = c;
    t.tx_byte = tx;
    t.ack_out = ack;
    t.sda_in  = pick_sda(sda_mode);
    push_tick(t);
    for (k = 1; k < ticks; k++) begin
      // stray commands while busy must be dropped
      t.cmd     = ($urandom_range(0, 99) < noise_pct) ? 3'($urandom_range(0, 7)) : CMD_NONE;
      t.tx_byte = 8'($urandom_range(0, 255));
      t.ack_out = 1'($urandom_range(0, 1));
      t.sda_in  = pick_sda(sda_mode);
      push_tick(t);
    end
    repeat ($urandom_range(0, 2)) push_idle_tick();
  endtask

  // Start, address, ack, one to three data bytes with acks, stop
  task automatic queue_transaction();
    logic [7:0] addr;
    int         nbytes;
    int         i;
    addr   = 8'($urandom_range(0, 255));
    nbytes = $urandom_range(1, 3);
    queue_command(CMD_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), SDA_RANDOM,
                  NOISE_PCT);
    queue_command(CMD_WRITE, addr, 1'($urandom_range(0, 1)), SDA_RANDOM, NOISE_PCT);
    queue_command(CMD_RECV_ACK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  SDA_RANDOM, NOISE_PCT);
    for (i = 0; i < nbytes; i++) begin
      if (addr[0]) begin
        queue_command(CMD_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      SDA_RANDOM, NOISE_PCT);
        queue_command(CMD_SEND_ACK, 8'($urandom_range(0, 255)), (i == nbytes - 1), SDA_RANDOM,
                      NOISE_PCT);
      end else begin
        queue_command(CMD_WRITE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      SDA_RANDOM, NOISE_PCT);
        queue_command(CMD_RECV_ACK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      SDA_RANDOM, NOISE_PCT);
      end
    end
    queue_command(CMD_STOP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), SDA_RANDOM,
                  NOISE_PCT);
  endtask

  // Wait until every queued tick has been checked and the sequencer is predicted idle
  task automatic wait_idle();
    logic quiet;
    quiet = 1'b0;
    while (!quiet) begin
      @(posedge clk);
      if (ticks_checked == ticks_queued) begin
        if (seq_cmd == CMD_NONE) quiet = 1'b1;
        else push_idle_tick();
      end
    end
  endtask

  task automatic write_step_cycles(logic [15:0] value);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!(cfg_valid && cfg_ready)) @(posedge clk);
    cfg_valid <= 1'b0;
    step_cycles_cfg = value;
  endtask

  // Transactions where they fit the tick budget, mixed with single commands in any order
  task automatic run_random_phase(logic [15:0] period, int unsigned budget);
    int unsigned first;
    int unsigned span;
    wait_idle();
    write_step_cycles(period);
    span  = (period == 16'd0) ? 1 : period;
    first = ticks_queued;
    while (ticks_queued - first < budget) begin
      if (ticks_queued - first + TXN_STEPS_MAX * span <= budget &&
          $urandom_range(0, 99) < 75) begin
        queue_transaction();
      end else begin
        queue_command(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)), SDA_RANDOM, NOISE_PCT);
      end
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset step length, code seven while idle
    queue_command(CMD_UNUSED, 8'hFF, 1'b1, SDA_HIGH, 0);
    queue_command(CMD_STOP, 8'h00, 1'b0, SDA_RANDOM, 0);

    // One tick per step: byte and level extremes, commands while busy
    wait_idle();
    write_step_cycles(16'd1);
    queue_command(CMD_START, 8'h00, 1'b0, SDA_RANDOM, 0);
    queue_command(CMD_WRITE, 8'h00, 1'b0, SDA_RANDOM, 0);
    queue_command(CMD_WRITE, 8'hFF, 1'b1, SDA_RANDOM, 0);
    queue_command(CMD_WRITE, 8'hA5, 1'b0, SDA_RANDOM, 100);
    queue_command(CMD_READ, 8'h00, 1'b0, SDA_HIGH, 0);
    queue_command(CMD_READ, 8'hFF, 1'b1, SDA_LOW, 0);
    queue_command(CMD_READ, 8'h3C, 1'b0, SDA_RANDOM, 100);
    queue_command(CMD_SEND_ACK, 8'h00, 1'b0, SDA_RANDOM, 0);
    queue_command(CMD_SEND_ACK, 8'hFF, 1'b1, SDA_RANDOM, 0);
    queue_command(CMD_RECV_ACK, 8'h00, 1'b0, SDA_LOW, 0);
    queue_command(CMD_UNUSED, 8'h55, 1'b0, SDA_RANDOM, 0);
    queue_command(CMD_RECV_ACK, 8'h00, 1'b0, SDA_HIGH, 0);
    queue_command(CMD_NONE, 8'hAA, 1'b1, SDA_RANDOM, 0);
    queue_command(CMD_STOP, 8'h00, 1'b0, SDA_RANDOM, 0);

    // Zero step length counts as one tick per step
    wait_idle();
    write_step_cycles(16'd0);
    queue_command(CMD_START, 8'h00, 1'b0, SDA_RANDOM, 0);
    queue_command(CMD_WRITE, 8'h5A, 1'b0, SDA_RANDOM, 0);
    queue_command(CMD_READ, 8'h00, 1'b0, SDA_RANDOM, 0);
    queue_command(CMD_RECV_ACK, 8'h00, 1'b0, SDA_RANDOM, 0);
    queue_command(CMD_STOP, 8'h00, 1'b0, SDA_RANDOM, 0);

    // Random traffic over several step lengths
    run_random_phase(16'd1, 150);
    wait_idle();
    calm = 1'b1;
    run_random_phase(16'd2, 200);
    wait_idle();
    calm = 1'b0;
    run_random_phase(16'd0, 80);
    run_random_phase(16'd3, 80);
    run_random_phase(16'($urandom_range(4, 6)), 80);

    // Long step length, shortest command
    wait_idle();
    write_step_cycles(16'd25);
    queue_command(CMD_STOP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), SDA_RANDOM,
                  NOISE_PCT);

    run_random_phase(16'd1, 60);

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_pins.size() == 0) begin
      $display("i2c_master_bit_sequencer regression: pass");
    end else begin
      $display("i2c_master_bit_sequencer regression: fail");
    end
    $finish;
  end

endmodule
